[hdl/cpwe_pkg.sv]
// shared constants and types for the crank power window estimator
`default_nettype none

package cpwe_pkg;

  // configuration register reset values
  localparam logic [15:0] GAIN_RESET   = 16'd395;
  localparam logic [15:0] WINDOW_RESET = 16'd1000;

  // apb address width and register index codes (index is paddr[2])
  localparam int   ADDR_W     = 3;
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  // force (q8) times rate (q4)
  localparam int PROD_W = 40;

  // elapsed ms to 1/1024 s ticks: floor(el * 1024 / 1000) = (el * TIME_RECIP) >> TIME_SHIFT
  localparam logic [23:0] TIME_RECIP  = 24'd8589935;
  localparam int          TIME_SHIFT  = 23;
  localparam int          TICK_PROD_W = 40;
  localparam int          TICK_W      = 17;

  // power scaling
  localparam int          QUOT_LIMIT  = 43;
  localparam int          GAIN_W      = 16;
  localparam int          SCALE_W     = QUOT_LIMIT + GAIN_W;
  localparam int          POWER_SHIFT = 28;
  localparam int          POWER_W     = 15;
  localparam logic [14:0] POWER_MAX   = 15'h7fff;

  localparam int QUEUE_DEPTH = 4;

  // fixed part of one window-close job
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] revs;
    logic [15:0] stamp;
    logic        by_rev;
  } job_info_t;

endpackage

`default_nettype wire

[hdl/cpwe_if.sv]
// sample and result channel interfaces
`default_nettype none

interface cpwe_sample_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] force_req;
  logic signed [15:0] crank_rate;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic        [15:0] elapsed_ms;

  modport source (output valid, force_req, crank_rate, accel_y, accel_z, elapsed_ms,
                  input ready);
  modport sink   (input valid, force_req, crank_rate, accel_y, accel_z, elapsed_ms,
                  output ready);
endinterface

interface cpwe_result_if;
  logic        valid;
  logic        ready;
  logic [14:0] power_watts;
  logic [15:0] revolution_count;
  logic [15:0] event_time;
  logic        closed_by_revolution;

  modport source (output valid, power_watts, revolution_count, event_time,
                  closed_by_revolution, input ready);
  modport sink   (input valid, power_watts, revolution_count, event_time,
                  closed_by_revolution, output ready);
endinterface

`default_nettype wire

[hdl/cpwe_fifo.sv]
// small job queue between the sample front end and the power back end
`default_nettype none

module cpwe_fifo #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full  = (fill == (AW+1)'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/cpwe_front.sv]
// sample front end: products, revolution detection, window accumulation
`default_nettype none

module cpwe_front #(
  parameter int SUM_WIDTH = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  cpwe_sample_if.sink                       sample,
  input  wire logic [15:0]                  window_ms,
  output logic                              push,
  output logic signed [SUM_WIDTH-1:0]       push_sum,
  output cpwe_pkg::job_info_t               push_info,
  input  wire logic                         queue_full
);

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic take;

  // stage a: captured sample
  logic               a_v;
  logic signed [23:0] a_force;
  logic signed [15:0] a_rate;
  logic [15:0]        a_el;
  logic               a_ypos, a_yneg, a_zpos, a_zneg;

  // stage b: products
  logic                                  b_v;
  logic signed [cpwe_pkg::PROD_W-1:0]    b_prod;
  logic [cpwe_pkg::TICK_W-1:0]           b_ticks;
  logic [15:0]                           b_el;
  logic                                  b_ypos, b_yneg, b_zpos, b_zneg;

  // window state
  logic                        half_armed;
  logic signed [SUM_WIDTH-1:0] product_sum;
  logic [15:0]                 sample_count;
  logic [15:0]                 rev_total;
  logic [15:0]                 time_total;

  logic signed [cpwe_pkg::PROD_W-1:0] prod_c;
  logic [cpwe_pkg::TICK_PROD_W-1:0]   tick_prod;
  logic signed [SUM_WIDTH:0]          sum_wide;
  logic signed [SUM_WIDTH-1:0]        sum_acc;
  logic [15:0]                        count_acc;
  logic                               rev_close, arm, time_close, close;
  logic [15:0]                        stamp;

  assign sample.ready = !a_v && !b_v && !queue_full;
  assign take         = sample.valid && sample.ready;

  assign prod_c    = cpwe_pkg::PROD_W'(a_force) * cpwe_pkg::PROD_W'(a_rate);
  assign tick_prod = cpwe_pkg::TICK_PROD_W'(a_el) * cpwe_pkg::TICK_PROD_W'(cpwe_pkg::TIME_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      a_v <= take;
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_force <= sample.force_req;
      a_rate  <= sample.crank_rate;
      a_el    <= sample.elapsed_ms;
      a_yneg  <= sample.accel_y[15];
      a_ypos  <= !sample.accel_y[15] && (sample.accel_y != '0);
      a_zneg  <= sample.accel_z[15];
      a_zpos  <= !sample.accel_z[15] && (sample.accel_z != '0);
    end
    if (a_v) begin
      b_prod  <= prod_c;
      b_ticks <= tick_prod[cpwe_pkg::TIME_SHIFT +: cpwe_pkg::TICK_W];
      b_el    <= a_el;
      b_ypos  <= a_ypos;
      b_yneg  <= a_yneg;
      b_zpos  <= a_zpos;
      b_zneg  <= a_zneg;
    end
  end

  always_comb begin
    rev_close  = half_armed && b_ypos && b_zpos;
    arm        = !half_armed && b_yneg && b_zneg;
    sum_wide   = (SUM_WIDTH+1)'(product_sum) + (SUM_WIDTH+1)'(b_prod);
    // saturate when the extra sign bit disagrees
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_acc = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_acc = sum_wide[SUM_WIDTH-1:0];
    end
    count_acc  = (sample_count == 16'hffff) ? sample_count : sample_count + 16'd1;
    time_close = (b_el > window_ms);
    close      = rev_close || time_close;
    stamp      = time_total + b_ticks[15:0];
  end

  assign push             = b_v && close;
  assign push_sum         = rev_close ? product_sum : sum_acc;
  assign push_info.count  = rev_close ? sample_count : count_acc;
  assign push_info.revs   = rev_close ? rev_total + 16'd1 : rev_total;
  assign push_info.stamp  = stamp;
  assign push_info.by_rev = rev_close;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_armed   <= 1'b0;
      product_sum  <= '0;
      sample_count <= '0;
      rev_total    <= '0;
      time_total   <= '0;
    end else if (b_v) begin
      if (rev_close) begin
        half_armed <= 1'b0;
        rev_total  <= rev_total + 16'd1;
      end else if (arm) begin
        half_armed <= 1'b1;
      end
      if (close) begin
        product_sum  <= '0;
        sample_count <= '0;
        time_total   <= stamp;
      end else begin
        product_sum  <= sum_acc;
        sample_count <= count_acc;
      end
    end
  end

  // only one sample in flight through the two stages
  assert property (@(posedge clk) disable iff (rst) a_v |-> !b_v)
    else $error("front: two samples in flight");

  // the queue has room whenever a window-close job is pushed
  assert property (@(posedge clk) disable iff (rst) push |-> !queue_full)
    else $error("front: push into full queue");

endmodule

`default_nettype wire

[hdl/cpwe_back.sv]
// power back end: restoring divide by sample count, gain scaling, result register
`default_nettype none

module cpwe_back #(
  parameter int SUM_WIDTH = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         queue_empty,
  output logic                              pop,
  input  wire logic signed [SUM_WIDTH-1:0]  job_sum,
  input  wire cpwe_pkg::job_info_t          job_info,
  input  wire logic [15:0]                  power_gain,
  cpwe_result_if.source                     result
);

  localparam int CNT_W = $clog2(SUM_WIDTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

  back_state_t state, state_next;

  logic [SUM_WIDTH-1:0]             dvd;
  logic [15:0]                      rem;
  logic [15:0]                      divisor;
  logic [CNT_W-1:0]                 bit_cnt;
  logic                             zero_div;
  logic                             over_lim;
  logic [cpwe_pkg::SCALE_W-1:0]     scaled;
  logic [15:0]                      revs;
  logic [15:0]                      stamp;
  logic                             by_rev;

  logic                             out_valid;
  logic [14:0]                      out_power;
  logic [15:0]                      out_revs;
  logic [15:0]                      out_stamp;
  logic                             out_by_rev;

  logic [SUM_WIDTH-1:0]             mag;
  logic [16:0]                      rem_sh;
  logic [16:0]                      rem_sub;
  logic                             rem_ge;
  logic [63:0]                      quot;
  logic [14:0]                      power_c;
  logic                             load;

  assign pop  = (state == ST_IDLE) && !queue_empty;
  assign load = (state == ST_DONE) && (!out_valid || result.ready);

  assign mag     = job_sum[SUM_WIDTH-1] ? (~job_sum + 1'b1) : job_sum;
  assign rem_sh  = {rem, dvd[SUM_WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign rem_ge  = (rem_sh >= {1'b0, divisor});
  assign quot    = 64'(dvd);

  always_comb begin
    if (zero_div) begin
      power_c = '0;
    end else if (over_lim ||
                 (scaled[cpwe_pkg::SCALE_W-1:cpwe_pkg::POWER_SHIFT+cpwe_pkg::POWER_W] != '0)) begin
      power_c = cpwe_pkg::POWER_MAX;
    end else begin
      power_c = scaled[cpwe_pkg::POWER_SHIFT +: cpwe_pkg::POWER_W];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (!queue_empty) state_next = ST_DIV;
      ST_DIV:  if (bit_cnt == CNT_W'(1)) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DONE;
      ST_DONE: if (load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dvd      <= mag;
        rem      <= '0;
        divisor  <= job_info.count;
        bit_cnt  <= CNT_W'(SUM_WIDTH);
        zero_div <= (job_info.count == '0) || (power_gain == '0);
        revs     <= job_info.revs;
        stamp    <= job_info.stamp;
        by_rev   <= job_info.by_rev;
      end
      ST_DIV: begin
        // one quotient bit per cycle
        rem     <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
        dvd     <= {dvd[SUM_WIDTH-2:0], rem_ge};
        bit_cnt <= bit_cnt - 1'b1;
      end
      ST_MUL: begin
        over_lim <= (quot[63:cpwe_pkg::QUOT_LIMIT] != '0);
        scaled   <= cpwe_pkg::SCALE_W'(quot[cpwe_pkg::QUOT_LIMIT-1:0]) *
                    cpwe_pkg::SCALE_W'(power_gain);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_power  <= power_c;
      out_revs   <= revs;
      out_stamp  <= stamp;
      out_by_rev <= by_rev;
    end
  end

  assign result.valid                = out_valid;
  assign result.power_watts          = out_power;
  assign result.revolution_count     = out_revs;
  assign result.event_time           = out_stamp;
  assign result.closed_by_revolution = out_by_rev;

  // partial remainder stays below a nonzero divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && divisor != '0) |-> (rem < divisor))
    else $error("back: remainder not below divisor");

  // divide runs exactly its bit count
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && bit_cnt == CNT_W'(1)) |=> (state == ST_MUL))
    else $error("back: divide did not finish on last bit");

  // empty window or zero gain gives zero power
  assert property (@(posedge clk) disable iff (rst)
    (load && zero_div) |=> (out_power == '0))
    else $error("back: empty window gave nonzero power");

endmodule

`default_nettype wire

[hdl/crank_power_window_estimator.sv]
// top level: config registers, front end, job queue and power back end
`default_nettype none

// Crank power window estimator. Samples enter on the sample channel; the front
// end takes a new sample only once the last one has left its stages (capture,
// force*rate and time-scale multiply, then window update) and the queue is not
// full. A sample that closes a window drops a job into a 4-entry queue; the
// back end pops a job only when idle, divides it with the restoring divider
// that produces one quotient bit per cycle, scales it by the gain and loads it
// into the result register once that is free, before it takes another job.
// The result register holds a finished result while the next job is divided.
// Registers: power_gain at address 0x0, window_ms at 0x4; write them only
// while idle.
module crank_power_window_estimator #(
  parameter int SUM_WIDTH = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cpwe_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  cpwe_sample_if.sink                       sample,
  cpwe_result_if.source                     result
);

  localparam int JOB_W = SUM_WIDTH + $bits(cpwe_pkg::job_info_t);

  logic [15:0] power_gain;
  logic [15:0] window_ms;
  logic        cfg_wr;

  logic                        push;
  logic signed [SUM_WIDTH-1:0] push_sum;
  cpwe_pkg::job_info_t         push_info;
  logic                        queue_full;
  logic                        queue_empty;
  logic                        pop;
  logic [JOB_W-1:0]            queue_out;
  logic signed [SUM_WIDTH-1:0] job_sum;
  cpwe_pkg::job_info_t         job_info;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_gain <= cpwe_pkg::GAIN_RESET;
      window_ms  <= cpwe_pkg::WINDOW_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        cpwe_pkg::REG_GAIN:   power_gain <= pwdata[15:0];
        cpwe_pkg::REG_WINDOW: window_ms  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cpwe_pkg::REG_GAIN:   prdata = {16'd0, power_gain};
      cpwe_pkg::REG_WINDOW: prdata = {16'd0, window_ms};
      default:              prdata = '0;
    endcase
  end

  cpwe_front #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .window_ms  (window_ms),
    .push       (push),
    .push_sum   (push_sum),
    .push_info  (push_info),
    .queue_full (queue_full)
  );

  cpwe_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (cpwe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({push_sum, push_info}),
    .full  (queue_full),
    .pop   (pop),
    .dout  (queue_out),
    .empty (queue_empty)
  );

  assign job_sum  = queue_out[JOB_W-1 -: SUM_WIDTH];
  assign job_info = queue_out[$bits(cpwe_pkg::job_info_t)-1:0];

  cpwe_back #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop         (pop),
    .job_sum     (job_sum),
    .job_info    (job_info),
    .power_gain  (power_gain),
    .result      (result)
  );

endmodule

`default_nettype wire
